/* rtl/core/kass_pkg.sv */
// ----------------------------------------------------------------------------
// kass_pkg
// Shared types, constants and helpers for the keypad angle stepper sequencer.
// ----------------------------------------------------------------------------
package kass_pkg;

  localparam int ENTRY_SLOTS = 4;
  localparam int COUNT_W     = 3;

  localparam logic [7:0]  KEY_NONE     = 8'h00;
  localparam logic [7:0]  KEY_RESET    = 8'h20;
  localparam logic [7:0]  KEY_HASH     = 8'h23;
  localparam logic [7:0]  KEY_A        = 8'h41;
  localparam logic [7:0]  KEY_B        = 8'h42;
  localparam logic [15:0] DIGIT_BASE   = 16'd48;

  // angle*512/45 exceeds 16 bits from this angle on
  localparam logic [15:0] ANGLE_SAT    = 16'd5760;
  // floor(x*512/45) = (x*RECIP_45) >> RECIP_SHIFT for x below ANGLE_SAT
  localparam logic [22:0] RECIP_45     = 23'd5965233;
  localparam int          RECIP_SHIFT  = 19;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_code;
  } kass_item_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic [15:0] steps_left;
    logic        reverse_dir;
    logic        entry_done;
  } kass_result_t;

  // key classification carried from the front end
  typedef struct packed {
    logic        is_term;
    logic        is_rev;
    logic [15:0] digit;
  } kass_key_t;

  typedef struct packed {
    logic       is_tick;
    logic       key_none;
    kass_key_t  key;
  } kass_op_t;

  function automatic kass_key_t kass_classify(input logic [7:0] code);
    kass_key_t k;
    k.is_term = code inside {KEY_HASH, KEY_A, KEY_B};
    k.is_rev  = (code == KEY_B);
    k.digit   = {8'h00, code} - DIGIT_BASE;
    return k;
  endfunction

  function automatic logic [3:0] kass_half_step(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/kass_front.sv */
// ----------------------------------------------------------------------------
// kass_front
// Accepts input transactions, classifies key codes and registers the result.
// ----------------------------------------------------------------------------
module kass_front import kass_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  kass_item_t item,
  output logic       op_valid,
  input  logic       op_stall,
  output kass_op_t   op
);

  logic     slot_valid;
  logic     slot_valid_next;
  kass_op_t slot_op;
  logic     accept;

  assign item_stall = slot_valid && op_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    slot_valid_next = slot_valid;
    if (accept) begin
      slot_valid_next = 1'b1;
    end else if (slot_valid && !op_stall) begin
      slot_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_op.is_tick  <= item.cmd;
      slot_op.key_none <= (item.key_code == KEY_NONE);
      slot_op.key      <= kass_classify(item.key_code);
    end
  end

  assign op_valid = slot_valid;
  assign op       = slot_op;

endmodule

/* rtl/core/kass_queue.sv */
// ----------------------------------------------------------------------------
// kass_queue
// Two-entry queue of classified operations between front and back end.
// ----------------------------------------------------------------------------
module kass_queue import kass_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_stall,
  input  kass_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_stall,
  output kass_op_t pop_op
);

  kass_op_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  logic       pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_op     = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/core/kass_exec.sv */
// ----------------------------------------------------------------------------
// kass_exec
// Back end: key press/release detector, angle entry, step target and
// half-step motor sequencer, with a registered result.
// ----------------------------------------------------------------------------
module kass_exec import kass_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_stall,
  input  kass_op_t     op,
  output logic         result_valid,
  input  logic         result_stall,
  output kass_result_t result
);

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_A    = 2'd1;
  localparam logic [1:0] MODE_B    = 2'd2;

  localparam kass_key_t LATCH_RESET = kass_classify(KEY_RESET);

  logic [1:0]         motor_mode, motor_mode_next;
  logic [2:0]         phase_index, phase_index_next;
  logic [15:0]        step_count, step_count_next;
  logic               reverse_flag, reverse_flag_next;
  logic [1:0]         key_mode, key_mode_next;
  kass_key_t          latched_key, latched_key_next;
  logic               press_flag, press_flag_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [3:0]         coil_reg, coil_reg_next;
  // running weighted sums of the keys in the current entry
  logic [15:0]        last_val, last_val_next;
  logic [15:0]        pair_val, pair_val_next;
  logic [15:0]        angle_val, angle_val_next;
  logic               done;
  logic               out_valid;
  kass_result_t       out_data;
  logic               pop;
  logic [35:0]        product;
  logic [15:0]        target;

  assign pop      = op_valid && (!out_valid || !result_stall);
  assign op_stall = !pop;

  assign product = 36'(angle_val[12:0]) * 36'(RECIP_45);
  assign target  = (angle_val >= ANGLE_SAT) ? 16'hFFFF : product[RECIP_SHIFT +: 16];

  always_comb begin
    motor_mode_next   = motor_mode;
    phase_index_next  = phase_index;
    step_count_next   = step_count;
    reverse_flag_next = reverse_flag;
    key_mode_next     = key_mode;
    latched_key_next  = latched_key;
    press_flag_next   = press_flag;
    entry_count_next  = entry_count;
    coil_reg_next     = coil_reg;
    last_val_next     = last_val;
    pair_val_next     = pair_val;
    angle_val_next    = angle_val;
    done              = 1'b0;

    if (op.is_tick) begin
      if (motor_mode inside {MODE_A, MODE_B}) begin
        if (step_count != 16'd0) begin
          phase_index_next = (motor_mode == MODE_A) ? phase_index + 3'd1 : phase_index - 3'd1;
          step_count_next  = step_count - 16'd1;
        end
        coil_reg_next = kass_half_step(phase_index_next);
      end
      motor_mode_next = reverse_flag ? MODE_B : MODE_A;
    end else begin
      case (key_mode)
        MODE_A: begin
          if (!op.key_none) begin
            latched_key_next = op.key;
            press_flag_next  = 1'b1;
          end
          key_mode_next = press_flag_next ? MODE_B : MODE_A;
        end
        MODE_B: begin
          if (op.key_none) begin
            press_flag_next = 1'b0;
            if (latched_key.is_term) begin
              reverse_flag_next = latched_key.is_rev;
              step_count_next   = target;
              entry_count_next  = '0;
              last_val_next     = 16'd0;
              pair_val_next     = 16'd0;
              angle_val_next    = 16'd0;
              done              = 1'b1;
            end else if (entry_count == COUNT_W'(ENTRY_SLOTS - 1)) begin
              entry_count_next = '0;
              last_val_next    = 16'd0;
              pair_val_next    = 16'd0;
              angle_val_next   = 16'd0;
            end else begin
              entry_count_next = entry_count + COUNT_W'(1);
              last_val_next    = latched_key.digit;
              pair_val_next    = latched_key.digit + 16'(last_val * 16'd10);
              angle_val_next   = latched_key.digit + 16'(pair_val * 16'd10);
            end
          end
          key_mode_next = press_flag_next ? MODE_B : MODE_A;
        end
        default: begin
          key_mode_next = MODE_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_mode   <= MODE_INIT;
      phase_index  <= 3'd0;
      step_count   <= 16'd0;
      reverse_flag <= 1'b0;
      key_mode     <= MODE_INIT;
      latched_key  <= LATCH_RESET;
      press_flag   <= 1'b0;
      entry_count  <= '0;
      coil_reg     <= 4'd0;
      last_val     <= 16'd0;
      pair_val     <= 16'd0;
      angle_val    <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        motor_mode   <= motor_mode_next;
        phase_index  <= phase_index_next;
        step_count   <= step_count_next;
        reverse_flag <= reverse_flag_next;
        key_mode     <= key_mode_next;
        latched_key  <= latched_key_next;
        press_flag   <= press_flag_next;
        entry_count  <= entry_count_next;
        coil_reg     <= coil_reg_next;
        last_val     <= last_val_next;
        pair_val     <= pair_val_next;
        angle_val    <= angle_val_next;
        out_valid    <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.coil_pattern <= coil_reg_next;
      out_data.steps_left   <= step_count_next;
      out_data.reverse_dir  <= reverse_flag_next;
      out_data.entry_done   <= done;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

endmodule

/* rtl/core/keypad_angle_stepper_sequencer.sv */
// ----------------------------------------------------------------------------
// keypad_angle_stepper_sequencer
// Keypad angle entry driving a half-step stepper motor sequencer.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   item     | item_valid / item_stall    | kass_item_t   (cmd, key_code)
//   result   | result_valid / result_stall| kass_result_t (one per item)
//
// One transaction per cycle while result_stall is low; items pass the front
// register, queue and result register. The result register is the only stage
// that must wait on result_stall; the two-entry queue lets the front keep
// accepting meanwhile. Synchronous reset clears all control and motor state.
// ----------------------------------------------------------------------------
module keypad_angle_stepper_sequencer import kass_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  kass_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output kass_result_t result
);

  logic     fr_valid;
  logic     fr_stall;
  kass_op_t fr_op;
  logic     bk_valid;
  logic     bk_stall;
  kass_op_t bk_op;

  kass_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .op_valid   (fr_valid),
    .op_stall   (fr_stall),
    .op         (fr_op)
  );

  kass_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_stall (fr_stall),
    .push_op    (fr_op),
    .pop_valid  (bk_valid),
    .pop_stall  (bk_stall),
    .pop_op     (bk_op)
  );

  kass_exec u_exec (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (bk_valid),
    .op_stall     (bk_stall),
    .op           (bk_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
